### src/association_table_sampler_core_macros.svh
// assertion helpers used by the sampler core
`ifndef ASSOCIATION_TABLE_SAMPLER_CORE_MACROS_SVH
`define ASSOCIATION_TABLE_SAMPLER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ATS_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ats: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ats: next-cycle check failed");

`endif

### src/ats_pkg.sv
package ats_pkg;

  // operation codes of an input word
  typedef enum logic [2:0] {
    OP_SPEAK  = 3'd0,
    OP_LISTEN = 3'd1,
    OP_LEARN  = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  // update applied to a row total and a column total
  typedef enum logic [1:0] {
    TOT_NONE = 2'd0,
    TOT_INC  = 2'd1,
    TOT_DEC  = 2'd2,
    TOT_SET  = 2'd3
  } tot_op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LEARN,
    ST_POP_WAIT,
    ST_DEC_WAIT,
    ST_PUSH,
    ST_INC_RD,
    ST_INC_WAIT,
    ST_SAMPLE,
    ST_RN,
    ST_SCAN,
    ST_WR_WAIT,
    ST_RD_WAIT,
    ST_DONE
  } st_e;

endpackage

### src/ats_totals.sv
module ats_totals #(
  parameter int MEANINGS = 16,
  parameter int SYMBOLS  = 16,
  parameter int MW       = 4,
  parameter int SW       = 4,
  parameter int CB       = 16,
  parameter int TB       = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ats_pkg::tot_op_e  tot_op_i,
  input  logic [MW-1:0]     row_i,
  input  logic [SW-1:0]     col_i,
  input  logic [CB-1:0]     old_i,
  input  logic [CB-1:0]     new_i,
  output logic [TB-1:0]     row_total_o,
  output logic [TB-1:0]     col_total_o
);
  import ats_pkg::*;

  logic [TB-1:0] row_tot_q [MEANINGS];
  logic [TB-1:0] col_tot_q [SYMBOLS];
  logic [TB-1:0] row_cur, col_cur;

  // totals at the selected row and column
  assign row_cur     = row_tot_q[row_i];
  assign col_cur     = col_tot_q[col_i];
  assign row_total_o = row_cur;
  assign col_total_o = col_cur;

  // row and column totals follow every count change
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEANINGS; i++) row_tot_q[i] <= '0;
      for (int j = 0; j < SYMBOLS; j++) col_tot_q[j] <= '0;
    end else begin
      case (tot_op_i)
        TOT_INC: begin
          row_tot_q[row_i] <= row_cur + TB'(1);
          col_tot_q[col_i] <= col_cur + TB'(1);
        end
        TOT_DEC: begin
          row_tot_q[row_i] <= row_cur - TB'(1);
          col_tot_q[col_i] <= col_cur - TB'(1);
        end
        TOT_SET: begin
          row_tot_q[row_i] <= row_cur - TB'(old_i) + TB'(new_i);
          col_tot_q[col_i] <= col_cur - TB'(old_i) + TB'(new_i);
        end
        default: ;
      endcase
    end
  end

endmodule

### src/association_table_sampler_core.sv
// Association table sampler: a meaning-by-symbol table of counts with row and
// column totals. Input words (op, meaning, symbol, draw, new_count) arrive on a
// valid/ready channel; each word gives one result word (picked_index,
// count_value, status) on a valid/ready output channel held in an output
// register, so the next word is taken while a result still waits.
// Speak scans the row entry by entry (up to SYMBOLS entries), listen scans the
// column (up to MEANINGS entries), after a learn when the column is empty. The
// single read-modify-write port of the count memory, one access per cycle with
// a registered read, sets the pace of each word; one word at a time.
// history_length is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, which the block itself does not enforce. After reset the
// count memory is cleared one entry per cycle, 2**(MW+SW) entries (256 at the
// default sizes), with in_ready_o low; totals, history pointers and the
// register reset at once. If the receiver stalls, the result stays in the
// output register and one more finished word waits inside.
`include "association_table_sampler_core_macros.svh"

module association_table_sampler_core #(
  parameter int MEANINGS    = 16,
  parameter int SYMBOLS     = 16,
  parameter int HISTORY_MAX = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  meaning_i,
  input  logic [3:0]  symbol_i,
  input  logic [15:0] draw_i,
  input  logic [15:0] new_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  picked_index_o,
  output logic [15:0] count_value_o,
  output logic [1:0]  status_o
);
  import ats_pkg::*;

  localparam int MW  = $clog2(MEANINGS);
  localparam int SW  = $clog2(SYMBOLS);
  localparam int AW  = MW + SW;
  localparam int HW  = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
  localparam int FW  = $clog2(HISTORY_MAX + 1);
  localparam int CB  = COUNT_BITS;
  localparam int CW  = (CB > 16) ? CB : 16;
  localparam int TB  = CB + ((MEANINGS > SYMBOLS) ? $clog2(MEANINGS) : $clog2(SYMBOLS));
  localparam int PW  = 16 + TB;
  localparam int IW  = (MW > SW) ? MW : SW;
  localparam logic [CB-1:0] COUNT_MAX = '1;

  // state and word registers
  st_e            state_q, state_d;
  op_e            op_q, op_d;
  logic [3:0]     m_raw_q, m_raw_d, s_raw_q, s_raw_d;
  logic [15:0]    draw_q, draw_d, nc_q, nc_d;
  logic [SW-1:0]  col_idx_q, col_idx_d;
  logic [1:0]     status_q, status_d;
  logic [3:0]     picked_q, picked_d;
  logic [15:0]    cval_q, cval_d;
  logic           samp_row_q, samp_row_d, ret_q, ret_d;
  logic [PW-1:0]  prod_q, prod_d;
  logic [TB-1:0]  rn_q, rn_d, acc_q, acc_d;
  logic [IW-1:0]  data_idx_q, data_idx_d, next_idx_q, next_idx_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [4:0]     cfg_len_q;
  logic [HW-1:0]  head_q [MEANINGS];
  logic [FW-1:0]  fill_q [MEANINGS];

  // output register
  logic           out_valid_q, out_load;
  logic [3:0]     out_picked_q;
  logic [15:0]    out_cval_q;
  logic [1:0]     out_status_q;

  // memories
  logic [CB-1:0]  cnt_mem [2**AW];
  logic [CB-1:0]  cnt_rd_q, cnt_wdata;
  logic [AW-1:0]  cnt_raddr, cnt_waddr;
  logic           cnt_we;
  logic [3:0]     hist_mem [2**(MW+HW)];
  logic [3:0]     hist_rd_q;
  logic [MW+HW-1:0] hist_raddr, hist_waddr;
  logic           hist_we;

  // history pointer update
  logic           hf_we;
  logic [HW-1:0]  head_new;
  logic [FW-1:0]  fill_new;

  // totals interface
  tot_op_e        tot_op;
  logic [CB-1:0]  tot_old, tot_new;
  logic [TB-1:0]  row_tot, col_tot;

  // shared conditions
  logic [MW-1:0]  m_idx;
  logic [SW-1:0]  s_idx;
  logic           in_range, need_pop, old_ok, cnt_nz, cnt_sat, hit;
  logic [HW-1:0]  head_cur, head_inc;
  logic [FW-1:0]  fill_cur;
  logic [31:0]    len_c, push_sum, push_pos;
  logic [TB-1:0]  samp_total, acc_new;
  logic [CB-1:0]  nc_clamped;
  logic           nc_over;
  logic [AW-1:0]  scan_addr_first, scan_addr_next;

  assign m_idx      = MW'(m_raw_q);
  assign s_idx      = SW'(s_raw_q);
  assign in_range   = (32'(m_raw_q) < MEANINGS) && (32'(s_raw_q) < SYMBOLS);
  assign head_cur   = head_q[m_idx];
  assign fill_cur   = fill_q[m_idx];
  assign head_inc   = (32'(head_cur) + 32'd1 >= HISTORY_MAX) ? '0 : head_cur + HW'(1);
  assign len_c      = (32'(cfg_len_q) > HISTORY_MAX) ? HISTORY_MAX : 32'(cfg_len_q);
  assign need_pop   = (len_c != 0) && (32'(fill_cur) >= len_c) && (fill_cur != '0);
  assign push_sum   = 32'(head_cur) + 32'(fill_cur);
  assign push_pos   = (push_sum >= HISTORY_MAX) ? push_sum - HISTORY_MAX : push_sum;
  assign old_ok     = 32'(hist_rd_q) < SYMBOLS;
  assign cnt_nz     = cnt_rd_q != '0;
  assign cnt_sat    = cnt_rd_q == COUNT_MAX;
  assign samp_total = samp_row_q ? row_tot : col_tot;
  assign acc_new    = acc_q + TB'(cnt_rd_q);
  assign hit        = acc_new >= rn_q;
  assign nc_over    = CW'(nc_q) > CW'(COUNT_MAX);
  assign nc_clamped = nc_over ? COUNT_MAX : CB'(nc_q);

  // scan addresses walk a row for speak and a column for listen
  assign scan_addr_first = samp_row_q ? {m_idx, SW'(0)} : {MW'(0), col_idx_q};
  assign scan_addr_next  = samp_row_q ? {m_idx, SW'(next_idx_q)}
                                      : {MW'(next_idx_q), col_idx_q};

  ats_totals #(
    .MEANINGS (MEANINGS),
    .SYMBOLS  (SYMBOLS),
    .MW       (MW),
    .SW       (SW),
    .CB       (CB),
    .TB       (TB)
  ) u_totals (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tot_op_i    (tot_op),
    .row_i       (m_idx),
    .col_i       (col_idx_q),
    .old_i       (tot_old),
    .new_i       (tot_new),
    .row_total_o (row_tot),
    .col_total_o (col_tot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!in_range) begin
          state_d = ST_DONE;
        end else begin
          case (op_q)
            OP_SPEAK:  state_d = ST_SAMPLE;
            OP_LISTEN: state_d = (col_tot == '0) ? ST_LEARN : ST_SAMPLE;
            OP_LEARN:  state_d = ST_LEARN;
            OP_WRITE:  state_d = ST_WR_WAIT;
            OP_READ:   state_d = ST_RD_WAIT;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_LEARN: begin
        if (need_pop) state_d = ST_POP_WAIT;
        else if (len_c != 0) state_d = ST_PUSH;
        else state_d = ST_INC_RD;
      end
      ST_POP_WAIT: state_d = old_ok ? ST_DEC_WAIT : ST_PUSH;
      ST_DEC_WAIT: state_d = ST_PUSH;
      ST_PUSH:     state_d = ST_INC_RD;
      ST_INC_RD:   state_d = ST_INC_WAIT;
      ST_INC_WAIT: state_d = ret_q ? ST_SAMPLE : ST_DONE;
      ST_SAMPLE:   state_d = (samp_total == '0) ? ST_DONE : ST_RN;
      ST_RN:       state_d = ST_SCAN;
      ST_SCAN:     if (hit) state_d = ST_DONE;
      ST_WR_WAIT:  state_d = ST_DONE;
      ST_RD_WAIT:  state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls per state
  always_comb begin
    op_d       = op_q;
    m_raw_d    = m_raw_q;
    s_raw_d    = s_raw_q;
    draw_d     = draw_q;
    nc_d       = nc_q;
    col_idx_d  = col_idx_q;
    status_d   = status_q;
    picked_d   = picked_q;
    cval_d     = cval_q;
    samp_row_d = samp_row_q;
    ret_d      = ret_q;
    prod_d     = prod_q;
    rn_d       = rn_q;
    acc_d      = acc_q;
    data_idx_d = data_idx_q;
    next_idx_d = next_idx_q;
    clr_d      = clr_q;
    cnt_raddr  = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = {m_idx, col_idx_q};
    cnt_wdata  = '0;
    hist_raddr = {m_idx, head_cur};
    hist_we    = 1'b0;
    hist_waddr = {m_idx, HW'(push_pos)};
    hf_we      = 1'b0;
    head_new   = head_cur;
    fill_new   = fill_cur;
    tot_op     = TOT_NONE;
    tot_old    = cnt_rd_q;
    tot_new    = nc_clamped;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(op_i);
          m_raw_d    = meaning_i;
          s_raw_d    = symbol_i;
          draw_d     = draw_i;
          nc_d       = new_count_i;
          col_idx_d  = SW'(symbol_i);
          status_d   = STAT_OK;
          picked_d   = '0;
          cval_d     = '0;
          samp_row_d = 1'b0;
          ret_d      = 1'b0;
        end
      end
      ST_DISPATCH: begin
        cnt_raddr = {m_idx, s_idx};
        if (op_q == OP_SPEAK) samp_row_d = 1'b1;
        if (op_q == OP_LISTEN) ret_d = 1'b1;
      end
      ST_LEARN: ;
      ST_POP_WAIT: begin
        // retire the oldest history entry
        cnt_raddr = {m_idx, SW'(hist_rd_q)};
        col_idx_d = SW'(hist_rd_q);
        hf_we     = 1'b1;
        head_new  = head_inc;
        fill_new  = fill_cur - FW'(1);
      end
      ST_DEC_WAIT: begin
        if (cnt_nz) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd_q - CB'(1);
          tot_op    = TOT_DEC;
        end
      end
      ST_PUSH: begin
        hist_we  = 1'b1;
        hf_we    = 1'b1;
        fill_new = fill_cur + FW'(1);
      end
      ST_INC_RD: begin
        cnt_raddr = {m_idx, s_idx};
        col_idx_d = s_idx;
      end
      ST_INC_WAIT: begin
        if (!cnt_sat) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd_q + CB'(1);
          tot_op    = TOT_INC;
        end else begin
          status_d = STAT_SAT;
        end
      end
      ST_SAMPLE: begin
        if (samp_total == '0) status_d = STAT_EMPTY;
        prod_d = PW'(draw_q) * PW'(samp_total);
      end
      ST_RN: begin
        rn_d       = prod_q[PW-1:16] + TB'(1);
        acc_d      = '0;
        cnt_raddr  = scan_addr_first;
        data_idx_d = '0;
        next_idx_d = IW'(1);
      end
      ST_SCAN: begin
        // running sum of the entries read so far
        if (hit) begin
          picked_d = 4'(data_idx_q);
        end else begin
          acc_d      = acc_new;
          cnt_raddr  = scan_addr_next;
          data_idx_d = next_idx_q;
          next_idx_d = next_idx_q + IW'(1);
        end
      end
      ST_WR_WAIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = {m_idx, s_idx};
        cnt_wdata = nc_clamped;
        tot_op    = TOT_SET;
        if (nc_over) status_d = STAT_SAT;
      end
      ST_RD_WAIT: begin
        cval_d = (CW'(cnt_rd_q) > CW'(16'hFFFF)) ? 16'hFFFF : 16'(cnt_rd_q);
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) out_load = 1'b1;
      end
      default: ;
    endcase
  end

  // control and word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cfg_len_q <= '0;
      for (int i = 0; i < MEANINGS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) cfg_len_q <= cfg_wdata_i;
      if (hf_we) begin
        head_q[m_idx] <= head_new;
        fill_q[m_idx] <= fill_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    m_raw_q    <= m_raw_d;
    s_raw_q    <= s_raw_d;
    draw_q     <= draw_d;
    nc_q       <= nc_d;
    col_idx_q  <= col_idx_d;
    status_q   <= status_d;
    picked_q   <= picked_d;
    cval_q     <= cval_d;
    samp_row_q <= samp_row_d;
    ret_q      <= ret_d;
    prod_q     <= prod_d;
    rn_q       <= rn_d;
    acc_q      <= acc_d;
    data_idx_q <= data_idx_d;
    next_idx_q <= next_idx_d;
  end

  // count memory, registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // history memory, registered read
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= s_raw_q;
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_picked_q <= picked_q;
      out_cval_q   <= cval_q;
      out_status_q <= status_q;
    end
  end

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign picked_index_o = out_picked_q;
  assign count_value_o  = out_cval_q;
  assign status_o       = out_status_q;

  `ATS_ASSERT_NEXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == ST_DISPATCH)
  `ATS_ASSERT_HOLDS(a_scan_no_write, state_q == ST_SCAN || state_q == ST_RN || state_q == ST_SAMPLE, !cnt_we)
  `ATS_ASSERT_HOLDS(a_fill_bound, state_q != ST_CLEAR, 32'(fill_cur) <= HISTORY_MAX)
  `ATS_ASSERT_NEXT(a_done_loads, state_q == ST_DONE && state_d == ST_IDLE, out_valid_o)

endmodule
